// File: src/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types, constants and the segment lookup for the LCD write serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdws_pkg;

  localparam int SEQ_W = 17;  // longest bit run of one item (header+addr+byte)
  localparam int CNT_W = 5;   // counts up to 31; an item needs at most 18 results

  // request types
  localparam logic REQ_DISPLAY = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  // mode headers sent at frame start
  localparam logic [2:0] MODE_DISPLAY = 3'b101;
  localparam logic [2:0] MODE_COMMAND = 3'b100;

  // register map
  localparam logic REG_DOT_MASK = 1'b0;
  localparam logic [7:0] DOT_MASK_RST = 8'h80;

  // result counts
  localparam logic [CNT_W-1:0] CNT_DISP_HDR = 5'd17;
  localparam logic [CNT_W-1:0] CNT_CMD_HDR  = 5'd12;
  localparam logic [CNT_W-1:0] CNT_DISP     = 5'd8;
  localparam logic [CNT_W-1:0] CNT_CMD      = 5'd9;

  localparam logic [7:0] SEG_DOT = 8'h08;
  localparam logic [7:0] SEG_P   = 8'h37;
  localparam logic [7:0] SEG_E   = 8'h1F;
  localparam logic [7:0] SEG_BAD = 8'hFF;

  localparam logic [7:0] DIGITS_EVEN [10] = '{
    8'h7d, 8'h60, 8'h3e, 8'h7a, 8'h63, 8'h5b, 8'h5f, 8'h70, 8'h7f, 8'h7b
  };
  localparam logic [7:0] DIGITS_OTHER [10] = '{
    8'hd7, 8'h06, 8'he3, 8'ha7, 8'h36, 8'hb5, 8'hf5, 8'h07, 8'hf7, 8'hb7
  };

  // one item's worth of serial work, handed from encoder to serializer
  typedef struct packed {
    logic [SEQ_W-1:0] bits;     // MSB goes out first
    logic [CNT_W-1:0] cnt;      // results including the release
    logic             release_cs;
  } load_t;

  // character code to segment byte at a given start address
  function automatic logic [7:0] seg_byte(input logic [7:0] code,
                                          input logic [5:0] addr,
                                          input logic [7:0] dot_mask);
    logic       even_low;
    logic       dot_addr;
    logic [3:0] d;
    logic [7:0] b;
    even_low = (addr == 6'd0) || (addr == 6'd2) || (addr == 6'd4) || (addr == 6'd6);
    dot_addr = (addr == 6'd8) || (addr == 6'd12) || (addr == 6'd14) ||
               (addr == 6'd22) || (addr == 6'd24);
    d = code[3:0];
    if (code >= 8'h30 && code <= 8'h39) begin
      b = even_low ? (DIGITS_EVEN[d] | dot_mask) : DIGITS_OTHER[d];
    end else if (code == 8'h50) begin
      b = (addr == 6'd6) ? SEG_P : 8'h00;
    end else if (code == 8'h45) begin
      b = (addr == 6'd6) ? SEG_E : 8'h00;
    end else begin
      b = SEG_BAD;
    end
    if (dot_addr) begin
      b = b | SEG_DOT;
    end
    if (code == 8'h00) begin
      b = 8'h00;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: src/lcdws_if.sv
// ----------------------------------------------------------------------------
// lcdws_in_if / lcdws_out_if
// Valid/ready channels for request items and serial result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdws_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;
  logic [7:0] command_byte;
  logic [5:0] start_address;
  logic       frame_start;
  logic       frame_end;

  modport source (output valid, req_type, char_code, command_byte, start_address,
                  frame_start, frame_end, input ready);
  modport sink   (input valid, req_type, char_code, command_byte, start_address,
                  frame_start, frame_end, output ready);
endinterface

interface lcdws_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic strobe_res;
  logic chip_select;
  logic last;

  modport source (output valid, data_bit, strobe_res, chip_select, last,
                  input ready);
  modport sink   (input valid, data_bit, strobe_res, chip_select, last,
                  output ready);
endinterface

`default_nettype wire

// File: src/lcdws_encode.sv
// ----------------------------------------------------------------------------
// lcdws_encode
// Frame tracking and bit-run build for one request item.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_encode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              req_type,
  input  wire logic [7:0]        char_code,
  input  wire logic [7:0]        command_byte,
  input  wire logic [5:0]        start_address,
  input  wire logic              frame_start,
  input  wire logic              frame_end,
  input  wire logic [7:0]        dot_mask,
  output lcdws_pkg::load_t       load,
  output logic                   frame_open
);

  logic       frame_open_r, frame_open_nxt;
  logic [5:0] frame_addr_r, frame_addr_nxt;
  logic [5:0] addr_use;
  logic [7:0] seg;
  logic       is_disp;

  assign is_disp  = (req_type == lcdws_pkg::REQ_DISPLAY);
  assign addr_use = (frame_start && is_disp) ? start_address : frame_addr_r;
  assign seg      = lcdws_pkg::seg_byte(char_code, addr_use, dot_mask);
  assign frame_open = frame_open_r;

  // bit run and result count
  always_comb begin
    load.bits       = '0;
    load.cnt        = '0;
    load.release_cs = frame_end;
    if (frame_start && is_disp) begin
      load.bits = {lcdws_pkg::MODE_DISPLAY, start_address, seg};
      load.cnt  = lcdws_pkg::CNT_DISP_HDR;
    end else if (frame_start) begin
      load.bits = {lcdws_pkg::MODE_COMMAND, command_byte, 1'b0, 5'b0};
      load.cnt  = lcdws_pkg::CNT_CMD_HDR;
    end else if (is_disp) begin
      load.bits = {seg, 9'b0};
      load.cnt  = lcdws_pkg::CNT_DISP;
    end else begin
      load.bits = {command_byte, 1'b0, 8'b0};
      load.cnt  = lcdws_pkg::CNT_CMD;
    end
    load.cnt = load.cnt + {4'b0, frame_end};
    // no open frame and no start: item is dropped
    if (!frame_start && !frame_open_r) begin
      load.cnt        = '0;
      load.release_cs = 1'b0;
    end
  end

  // frame state update on accepted item
  always_comb begin
    frame_open_nxt = frame_open_r;
    frame_addr_nxt = frame_addr_r;
    if (accept && (frame_start || frame_open_r)) begin
      frame_open_nxt = !frame_end;
      if (frame_start && is_disp) begin
        frame_addr_nxt = start_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      frame_addr_r <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      frame_addr_r <= frame_addr_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/lcdws_serialize.sv
// ----------------------------------------------------------------------------
// lcdws_serialize
// Shift register of pending bits feeding a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_serialize (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  lcdws_pkg::load_t     load,
  lcdws_out_if.source          out_ch
);

  logic [lcdws_pkg::SEQ_W-1:0] bits_r, bits_nxt;
  logic [lcdws_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic                        rel_r, rel_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        data_r, data_nxt;
  logic                        strobe_r, strobe_nxt;
  logic                        cs_r, cs_nxt;
  logic                        last_r, last_nxt;
  logic                        slot_free;
  logic                        emit;
  logic                        final_one;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign final_one = (rem_r == lcdws_pkg::CNT_W'(1));
  assign emit      = (rem_r != '0) && slot_free;
  // take the next item once the current one has its last result moving out
  assign in_ready  = (rem_r == '0) || (final_one && slot_free);

  always_comb begin
    bits_nxt      = bits_r;
    rem_nxt       = rem_r;
    rel_nxt       = rel_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    data_nxt      = data_r;
    strobe_nxt    = strobe_r;
    cs_nxt        = cs_r;
    last_nxt      = last_r;
    // emit one result
    if (emit) begin
      out_valid_nxt = 1'b1;
      last_nxt      = final_one;
      if (final_one && rel_r) begin
        data_nxt   = 1'b0;
        strobe_nxt = 1'b0;
        cs_nxt     = 1'b0;
      end else begin
        data_nxt   = bits_r[lcdws_pkg::SEQ_W-1];
        strobe_nxt = 1'b1;
        cs_nxt     = 1'b1;
      end
      bits_nxt = {bits_r[lcdws_pkg::SEQ_W-2:0], 1'b0};
      rem_nxt  = rem_r - lcdws_pkg::CNT_W'(1);
    end
    // new item load
    if (in_valid && in_ready) begin
      bits_nxt = load.bits;
      rem_nxt  = load.cnt;
      rel_nxt  = load.release_cs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bits_r   <= bits_nxt;
    rel_r    <= rel_nxt;
    data_r   <= data_nxt;
    strobe_r <= strobe_nxt;
    cs_r     <= cs_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_bit    = data_r;
  assign out_ch.strobe_res  = strobe_r;
  assign out_ch.chip_select = cs_r;
  assign out_ch.last        = last_r;

endmodule

`default_nettype wire

// File: src/segment_lcd_write_serializer_core.sv
// ----------------------------------------------------------------------------
// segment_lcd_write_serializer_core
// Three-wire segment LCD write serializer, top level.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request items (display character or command byte) with frame
//            start/end flags. An item is taken when valid and ready are high.
//   out_ch : one result per write strobe or chip-select release, MSB first;
//            last marks the final result of an item.
//   APB    : one register, dot_mask at byte address 0 (paddr[2] selects).
// Flow: a taken item is loaded into the shift register, and its results move
//   from there into the output register. An item produces 8, 9, 12 or 17 bit
//   results, plus one release result when it ends its frame; the output
//   register is the rate limit. The next item is taken in the cycle its
//   predecessor's last result moves into the output register.
//   Items arriving with no open frame and no frame start give no results.
// Reset: no frame open, latched address 0, dot_mask 0x80, output empty.
// Stall: when out_ch.ready is low the result holds and the shifter waits.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_lcd_write_serializer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lcdws_in_if.sink         in_ch,
  lcdws_out_if.source      out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]       dot_mask_r, dot_mask_nxt;
  logic             reg_sel;
  logic             accept;
  logic             frame_open;
  lcdws_pkg::load_t load;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == lcdws_pkg::REG_DOT_MASK);
  assign prdata  = reg_sel ? {24'b0, dot_mask_r} : 32'b0;

  always_comb begin
    dot_mask_nxt = dot_mask_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      dot_mask_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_mask_r <= lcdws_pkg::DOT_MASK_RST;
    end else begin
      dot_mask_r <= dot_mask_nxt;
    end
  end

  assign accept = in_ch.valid && in_ch.ready;

  lcdws_encode u_encode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .req_type      (in_ch.req_type),
    .char_code     (in_ch.char_code),
    .command_byte  (in_ch.command_byte),
    .start_address (in_ch.start_address),
    .frame_start   (in_ch.frame_start),
    .frame_end     (in_ch.frame_end),
    .dot_mask      (dot_mask_r),
    .load          (load),
    .frame_open    (frame_open)
  );

  lcdws_serialize u_serialize (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .load     (load),
    .out_ch   (out_ch)
  );

  // a frame started without an end stays open
  a_frame_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.frame_start && !in_ch.frame_end) |=> frame_open)
    else $error("frame not open after frame start");

  // a frame end on an accepted item closes it
  a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.frame_end) |=> !frame_open)
    else $error("frame still open after frame end");

  // a result that is not last is followed by another result
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |=> out_ch.valid)
    else $error("result run broken before last");

  // a selected result always carries a strobe
  a_release_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.strobe_res) |-> (out_ch.last && !out_ch.chip_select))
    else $error("release result malformed");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for segment_lcd_write_serializer_core. A directed list
// of characters and commands runs first, then random frames under three
// backpressure mixes. A shadow model turns every accepted item into its
// serial strobe sequence; the output stream is checked strobe by strobe.
// ----------------------------------------------------------------------------

module testbench;

  localparam int SETTLE_CYC = 20;
  localparam int ITEMS_PER_PHASE = 27;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_E    = 8'h45;

  localparam logic [7:0] EVEN_GLYPHS [10] = '{
    8'h7d, 8'h60, 8'h3e, 8'h7a, 8'h63, 8'h5b, 8'h5f, 8'h70, 8'h7f, 8'h7b
  };
  localparam logic [7:0] ODD_GLYPHS [10] = '{
    8'hd7, 8'h06, 8'he3, 8'ha7, 8'h36, 8'hb5, 8'hf5, 8'h07, 8'hf7, 8'hb7
  };

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [7:0] command_byte;
    logic [5:0] start_address;
    logic       frame_start;
    logic       frame_end;
  } lcd_req_t;

  typedef struct packed {
    logic data_bit;
    logic strobe_res;
    logic chip_select;
    logic last;
  } lcd_strobe_t;

  // directed row: item fields, then an optional hand-typed segment byte
  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [7:0] command_byte;
    logic [5:0] start_address;
    logic       frame_start;
    logic       frame_end;
    logic       pinned;
    logic [7:0] seg_byte;
  } lcd_row_t;

  localparam int N_ROWS = 25;
  localparam lcd_row_t DIRECTED [N_ROWS] = '{
    // '8' at address 0 with the reset dot mask
    '{lcdws_pkg::REQ_DISPLAY, 8'h38, 8'h00, 6'd0,  1'b1, 1'b0, 1'b1, 8'hFF},
    '{lcdws_pkg::REQ_DISPLAY, 8'h30, 8'h00, 6'd0,  1'b0, 1'b0, 1'b0, 8'h00},
    // blank closes the frame
    '{lcdws_pkg::REQ_DISPLAY, 8'h00, 8'hFF, 6'd0,  1'b0, 1'b1, 1'b1, 8'h00},
    // no frame open: dropped
    '{lcdws_pkg::REQ_COMMAND, 8'h41, 8'h3C, 6'd33, 1'b0, 1'b1, 1'b0, 8'h00},
    '{lcdws_pkg::REQ_COMMAND, 8'h00, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b0, 8'h00},
    '{lcdws_pkg::REQ_COMMAND, 8'h00, 8'h00, 6'd0,  1'b1, 1'b0, 1'b0, 8'h00},
    // character inside a command frame, old latched address
    '{lcdws_pkg::REQ_DISPLAY, 8'h35, 8'h00, 6'd0,  1'b0, 1'b0, 1'b0, 8'h00},
    // frame start while open, P and E at address 6
    '{lcdws_pkg::REQ_DISPLAY, 8'h50, 8'h00, 6'd6,  1'b1, 1'b0, 1'b1, 8'h37},
    '{lcdws_pkg::REQ_DISPLAY, 8'h45, 8'h00, 6'd63, 1'b0, 1'b0, 1'b1, 8'h1F},
    '{lcdws_pkg::REQ_DISPLAY, 8'h41, 8'h00, 6'd0,  1'b0, 1'b0, 1'b1, 8'hFF},
    // command inside a display frame
    '{lcdws_pkg::REQ_COMMAND, 8'h00, 8'hA5, 6'd0,  1'b0, 1'b1, 1'b0, 8'h00},
    // dot addresses
    '{lcdws_pkg::REQ_DISPLAY, 8'h50, 8'h00, 6'd8,  1'b1, 1'b0, 1'b1, 8'h08},
    '{lcdws_pkg::REQ_DISPLAY, 8'h00, 8'h00, 6'd0,  1'b0, 1'b0, 1'b1, 8'h00},
    '{lcdws_pkg::REQ_DISPLAY, 8'hFF, 8'h5A, 6'd0,  1'b0, 1'b1, 1'b1, 8'hFF},
    '{lcdws_pkg::REQ_DISPLAY, 8'h39, 8'h00, 6'd63, 1'b1, 1'b1, 1'b0, 8'h00},
    '{lcdws_pkg::REQ_DISPLAY, 8'h31, 8'h00, 6'd12, 1'b1, 1'b0, 1'b0, 8'h00},
    '{lcdws_pkg::REQ_DISPLAY, 8'h45, 8'h00, 6'd14, 1'b1, 1'b0, 1'b1, 8'h08},
    '{lcdws_pkg::REQ_DISPLAY, 8'h33, 8'h00, 6'd22, 1'b1, 1'b0, 1'b0, 8'h00},
    '{lcdws_pkg::REQ_DISPLAY, 8'h37, 8'h00, 6'd24, 1'b1, 1'b1, 1'b0, 8'h00},
    '{lcdws_pkg::REQ_DISPLAY, 8'h32, 8'h00, 6'd2,  1'b1, 1'b0, 1'b0, 8'h00},
    '{lcdws_pkg::REQ_DISPLAY, 8'h34, 8'h00, 6'd4,  1'b1, 1'b1, 1'b0, 8'h00},
    // just outside the digit range, and P off address 6
    '{lcdws_pkg::REQ_DISPLAY, 8'h2F, 8'h00, 6'd1,  1'b1, 1'b0, 1'b1, 8'hFF},
    '{lcdws_pkg::REQ_DISPLAY, 8'h50, 8'h00, 6'd1,  1'b0, 1'b1, 1'b1, 8'h00},
    '{lcdws_pkg::REQ_COMMAND, 8'h00, 8'h81, 6'd21, 1'b1, 1'b0, 1'b0, 8'h00},
    '{lcdws_pkg::REQ_COMMAND, 8'h00, 8'h7E, 6'd42, 1'b0, 1'b1, 1'b0, 8'h00}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lcdws_in_if  in_bus ();
  lcdws_out_if out_bus ();

  segment_lcd_write_serializer_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow state
  logic [7:0]  dot_mask_shadow;
  logic [5:0]  latched_addr;
  logic        frame_is_open;
  lcd_strobe_t pending_strobes [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int strobes_seen = 0;
  int items_active = 0;
  int items_dropped = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // segment byte for a character at a latched address
  function automatic logic [7:0] glyph_for(input logic [7:0] code,
                                           input logic [5:0] addr);
    logic [7:0] b;
    logic [3:0] d;
    logic       even_low;
    logic       dot_spot;
    even_low = (addr == 6'd0) || (addr == 6'd2) || (addr == 6'd4) || (addr == 6'd6);
    dot_spot = (addr == 6'd8) || (addr == 6'd12) || (addr == 6'd14) ||
               (addr == 6'd22) || (addr == 6'd24);
    if (code == 8'h00) begin
      return 8'h00;
    end
    if (code >= CH_ZERO && code <= CH_NINE) begin
      d = 4'(code - CH_ZERO);
      b = even_low ? (EVEN_GLYPHS[d] | dot_mask_shadow) : ODD_GLYPHS[d];
    end else if (code == CH_P) begin
      b = (addr == 6'd6) ? 8'h37 : 8'h00;
    end else if (code == CH_E) begin
      b = (addr == 6'd6) ? 8'h1F : 8'h00;
    end else begin
      b = 8'hFF;
    end
    if (dot_spot) begin
      b = b | 8'h08;
    end
    return b;
  endfunction

  task automatic push_bits(input logic [7:0] value, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      pending_strobes.push_back('{value[i], 1'b1, 1'b1, 1'b0});
    end
  endtask

  // expected strobes of one accepted item; pin overrides the segment byte
  task automatic predict_strobes(input lcd_req_t it, input logic pin,
                                 input logic [7:0] pin_byte);
    lcd_strobe_t tail;
    logic [7:0]  seg;
    if (!it.frame_start && !frame_is_open) begin
      items_dropped++;
      return;
    end
    items_active++;
    if (it.frame_start) begin
      frame_is_open = 1'b1;
      push_bits({5'd0, (it.req_type == lcdws_pkg::REQ_COMMAND) ?
                 lcdws_pkg::MODE_COMMAND : lcdws_pkg::MODE_DISPLAY}, 3);
      if (it.req_type == lcdws_pkg::REQ_DISPLAY) begin
        latched_addr = it.start_address;
        push_bits({2'b00, it.start_address}, 6);
      end
    end
    if (it.req_type == lcdws_pkg::REQ_DISPLAY) begin
      seg = pin ? pin_byte : glyph_for(it.char_code, latched_addr);
      push_bits(seg, 8);
    end else begin
      push_bits(it.command_byte, 8);
      push_bits(8'h00, 1);
    end
    if (it.frame_end) begin
      pending_strobes.push_back('{1'b0, 1'b0, 1'b0, 1'b0});
      frame_is_open = 1'b0;
    end
    tail = pending_strobes.pop_back();
    tail.last = 1'b1;
    pending_strobes.push_back(tail);
  endtask

  // offer one item, with random idle cycles ahead of it
  task automatic send_item(input lcd_req_t it, input logic pin,
                           input logic [7:0] pin_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.req_type      <= it.req_type;
    in_bus.char_code     <= it.char_code;
    in_bus.command_byte  <= it.command_byte;
    in_bus.start_address <= it.start_address;
    in_bus.frame_start   <= it.frame_start;
    in_bus.frame_end     <= it.frame_end;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_strobes(it, 1'b0 | pin, pin_byte);
  endtask

  function automatic logic [5:0] pick_addr();
    logic [5:0] even_spots [4] = '{6'd0, 6'd2, 6'd4, 6'd6};
    logic [5:0] dot_spots [5] = '{6'd8, 6'd12, 6'd14, 6'd22, 6'd24};
    case ($urandom_range(3))
      0: return even_spots[2'($urandom_range(3))];
      1: return dot_spots[3'($urandom_range(4))];
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return CH_ZERO + 8'($urandom_range(9));
    if (roll < 60) return $urandom_range(1) ? CH_P : CH_E;
    if (roll < 65) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // mostly well-formed frames of 1..4 items, some loose noise items
  task automatic send_random_frame();
    lcd_req_t it;
    int       n;
    logic     kind;
    if ($urandom_range(99) < 15) begin
      it = lcd_req_t'($urandom);
      it.frame_start = 1'($urandom_range(1));
      it.frame_end = 1'($urandom_range(1));
      send_item(it, 1'b0, 8'h00);
      return;
    end
    n = $urandom_range(4, 1);
    kind = $urandom_range(2) == 0 ? lcdws_pkg::REQ_COMMAND : lcdws_pkg::REQ_DISPLAY;
    for (int i = 0; i < n; i++) begin
      it.req_type      = (i > 0 && $urandom_range(4) == 0) ? ~kind : kind;
      it.char_code     = pick_char();
      it.command_byte  = 8'($urandom_range(255));
      it.start_address = pick_addr();
      it.frame_start   = (i == 0);
      it.frame_end     = (i == n - 1);
      send_item(it, 1'b0, 8'h00);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = items_active + count;
    while (items_active < target) send_random_frame();
    in_bus.valid <= 1'b0;
  endtask

  // wait for the output to drain, then let the pipe go quiet
  task automatic settle();
    while (pending_strobes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write of dot_mask followed by a read back
  task automatic write_dot_mask(input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lcdws_pkg::REG_DOT_MASK, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    dot_mask_shadow = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== val) begin
      mismatches++;
      $display("%0t: dot_mask read back: expected %h, got %h", $time, val, prdata[7:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random backpressure and strobe check
  always @(posedge clk) begin
    lcd_strobe_t got;
    lcd_strobe_t want;
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.data_bit, out_bus.strobe_res, out_bus.chip_select, out_bus.last};
      strobes_seen++;
      if (pending_strobes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected strobe: expected none, got bit=%b stb=%b cs=%b last=%b",
                 $time, got.data_bit, got.strobe_res, got.chip_select, got.last);
      end else begin
        want = pending_strobes.pop_front();
        if (got.data_bit !== want.data_bit || got.strobe_res !== want.strobe_res ||
            got.chip_select !== want.chip_select || got.last !== want.last) begin
          mismatches++;
          $display("%0t: strobe mismatch: expected bit=%b stb=%b cs=%b last=%b,",
                   $time, want.data_bit, want.strobe_res, want.chip_select, want.last);
          $display("  got bit=%b stb=%b cs=%b last=%b",
                   got.data_bit, got.strobe_res, got.chip_select, got.last);
        end
      end
    end
  end

  initial begin
    lcd_req_t it;
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_bus.valid         = 1'b0;
    in_bus.req_type      = lcdws_pkg::REQ_DISPLAY;
    in_bus.char_code     = '0;
    in_bus.command_byte  = '0;
    in_bus.start_address = '0;
    in_bus.frame_start   = 1'b0;
    in_bus.frame_end     = 1'b0;
    dot_mask_shadow      = lcdws_pkg::DOT_MASK_RST;
    latched_addr         = '0;
    frame_is_open        = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender idles 32%, receiver 81%
    send_idle_pct = 32;
    recv_idle_pct = 81;
    for (int r = 0; r < N_ROWS; r++) begin
      it.req_type      = DIRECTED[r].req_type;
      it.char_code     = DIRECTED[r].char_code;
      it.command_byte  = DIRECTED[r].command_byte;
      it.start_address = DIRECTED[r].start_address;
      it.frame_start   = DIRECTED[r].frame_start;
      it.frame_end     = DIRECTED[r].frame_end;
      send_item(it, DIRECTED[r].pinned, DIRECTED[r].seg_byte);
    end
    in_bus.valid <= 1'b0;
    settle();
    write_dot_mask(8'($urandom_range(255)));
    run_random(ITEMS_PER_PHASE);
    settle();

    // phase 2: sender idles 81%, receiver 32%
    write_dot_mask(8'h00);
    send_idle_pct = 81;
    recv_idle_pct = 32;
    run_random(ITEMS_PER_PHASE);
    settle();

    // phase 3: no idling on either side
    write_dot_mask(8'hFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    settle();

    $display("Covered %0d serialized items and %0d dropped ones, %0d strobes checked,",
             items_active, items_dropped, strobes_seen);
    $display("dot_mask at reset, random, all clear and all set, three backpressure mixes.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("watchdog expired with %0d strobes outstanding", pending_strobes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
